### hdl/sdbl_pkg.sv
// Shared constants and types for the drainage basin labeler.
`default_nettype none
package sdbl_pkg;
    localparam int MAX_ROWS = 128;
    localparam int MAX_COLS = 128;
    localparam int ALT_BITS = 16;

    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CELLS   = MAX_ROWS * MAX_COLS;
    localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_R_W = $clog2(MAX_ROWS + 1);
    localparam int CNT_C_W = $clog2(MAX_COLS + 1);
    localparam int PASS_W  = $clog2(CELL_W + 1);

    // fixed field widths
    localparam int FUNC_W = 1;
    localparam int IROW_W = 7;
    localparam int ICOL_W = 7;
    localparam int IALT_W = 16;
    localparam int NUM_W  = 14;
    localparam int CFG_W  = 8;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam logic CFG_ROWS   = 1'b0;
    localparam logic CFG_COLS   = 1'b1;

    // one word of the link memory: basin number tag of a sink plus drain pointer
    typedef struct packed {
        logic             numbered;
        logic [NUM_W-1:0] num;
        logic [CELL_W-1:0] ptr;
    } t_link;
endpackage
`default_nettype wire

### hdl/sdbl_in_if.sv
// Input channel: write or query beats.
`default_nettype none
interface sdbl_in_if import sdbl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IROW_W-1:0] row;
    logic [ICOL_W-1:0] col;
    logic [IALT_W-1:0] altitude;
    modport source (output valid, func, row, col, altitude, input ready);
    modport sink   (input valid, func, row, col, altitude, output ready);
endinterface
`default_nettype wire

### hdl/sdbl_out_if.sv
// Output channel: basin number beats.
`default_nettype none
interface sdbl_out_if import sdbl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] basin_number;
    modport source (output valid, basin_number, input ready);
    modport sink   (input valid, basin_number, output ready);
endinterface
`default_nettype wire

### hdl/steepest_descent_basin_labeler.sv
// Steepest-descent drainage basin labeler, top level.
//
// Write beats (func 0) store one altitude. A query beat (func 1) returns the
// basin number of the named cell. With the map unchanged a query makes two
// dependent reads of the link memory before the result register is loaded.
// After any altitude or register write, the next query first recomputes the
// map over all rows*cols active cells: the drain pointers (five altitude
// reads per cell through the single altitude read port), pointer doubling
// (14 passes at 128x128) and basin numbering, all on the link memory's one
// read port. The input is not ready during a recompute or query; a write may
// be taken while a result waits on the output.
`default_nettype none
module steepest_descent_basin_labeler import sdbl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    sdbl_in_if.sink               i_in,
    sdbl_out_if.source            o_out
);
    typedef enum logic [2:0] {S_IDLE, S_DOWN, S_JUMP, S_NUM, S_QRY, S_OUT} t_state;

    t_state              r_state;
    logic [2:0]          r_step;
    logic [PASS_W-1:0]   r_pass;
    logic [ROW_W-1:0]    r_r;
    logic [COL_W-1:0]    r_c;
    logic                r_changed;
    logic [CFG_W-1:0]    r_rows_cfg, r_cols_cfg;
    logic [ALT_BITS-1:0] r_best_alt;
    logic [CELL_W-1:0]   r_best;
    logic [CELL_W-1:0]   r_sink;
    logic [NUM_W-1:0]    r_next;
    logic [IROW_W-1:0]   r_qrow;
    logic [ICOL_W-1:0]   r_qcol;
    logic [NUM_W-1:0]    r_qnum;
    logic                r_out_valid;
    logic [NUM_W-1:0]    r_out_num;

    // memories
    logic [ALT_BITS-1:0] alt_mem [CELLS];
    t_link               link_mem [CELLS];
    logic [ALT_BITS-1:0] r_alt_rd;
    t_link               r_link_rd;

    logic                alt_we;
    logic [CELL_W-1:0]   alt_waddr, alt_raddr;
    logic                link_we;
    logic [CELL_W-1:0]   link_waddr, link_raddr;
    t_link               link_wdata;

    // active grid
    logic [CNT_R_W-1:0]  act_rows;
    logic [CNT_C_W-1:0]  act_cols;

    always_comb begin
        if (r_rows_cfg == '0) act_rows = CNT_R_W'(1);
        else if (32'(r_rows_cfg) > MAX_ROWS) act_rows = CNT_R_W'(MAX_ROWS);
        else act_rows = CNT_R_W'(r_rows_cfg);
        if (r_cols_cfg == '0) act_cols = CNT_C_W'(1);
        else if (32'(r_cols_cfg) > MAX_COLS) act_cols = CNT_C_W'(MAX_COLS);
        else act_cols = CNT_C_W'(r_cols_cfg);
    end

    logic last_c, last_r, last_cell;
    logic [CELL_W-1:0] cur;
    assign last_c    = (CNT_C_W'(r_c) + CNT_C_W'(1)) == act_cols;
    assign last_r    = (CNT_R_W'(r_r) + CNT_R_W'(1)) == act_rows;
    assign last_cell = last_c && last_r;
    assign cur       = CELL_W'(CELL_W'(r_r) * CELL_W'(MAX_COLS) + CELL_W'(r_c));

    // neighbor table: here, north, west, east, south
    logic [CELL_W-1:0] nb_addr [5];
    logic              nb_ok   [5];
    always_comb begin
        nb_addr[0] = cur;
        nb_addr[1] = cur - CELL_W'(MAX_COLS);
        nb_addr[2] = cur - CELL_W'(1);
        nb_addr[3] = cur + CELL_W'(1);
        nb_addr[4] = cur + CELL_W'(MAX_COLS);
        nb_ok[0]   = 1'b0;
        nb_ok[1]   = r_r != '0;
        nb_ok[2]   = r_c != '0;
        nb_ok[3]   = !last_c;
        nb_ok[4]   = !last_r;
    end

    logic [2:0]        cand_k;
    logic              cand_lower;
    logic [CELL_W-1:0] best_now;
    assign cand_k     = r_step - 3'd1;
    assign cand_lower = (r_step >= 3'd2) && nb_ok[cand_k] && (r_alt_rd < r_best_alt);
    assign best_now   = cand_lower ? nb_addr[cand_k] : r_best;

    // query target
    logic              q_in;
    logic [CELL_W-1:0] q_idx;
    assign q_in  = (CNT_R_W'(r_qrow) < act_rows) && (CNT_C_W'(r_qcol) < act_cols)
                   && (32'(r_qrow) < MAX_ROWS) && (32'(r_qcol) < MAX_COLS);
    assign q_idx = CELL_W'(CELL_W'(r_qrow) * CELL_W'(MAX_COLS) + CELL_W'(r_qcol));

    logic in_acc, wr_ok;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign wr_ok      = (32'(i_in.row) < MAX_ROWS) && (32'(i_in.col) < MAX_COLS);

    always_comb begin
        alt_we      = in_acc && (i_in.func == FUNC_WRITE) && wr_ok;
        alt_waddr   = CELL_W'(CELL_W'(i_in.row) * CELL_W'(MAX_COLS) + CELL_W'(i_in.col));
        alt_raddr   = (r_step < 3'd5) ? nb_addr[r_step] : cur;
        link_we     = 1'b0;
        link_waddr  = cur;
        link_raddr  = cur;
        link_wdata  = '{numbered: 1'b0, num: '0, ptr: r_link_rd.ptr};
        unique case (r_state)
            S_DOWN: begin
                link_we    = (r_step == 3'd5);
                link_wdata = '{numbered: 1'b0, num: '0, ptr: best_now};
            end
            S_JUMP: begin
                if (r_step == 3'd1) link_raddr = r_link_rd.ptr;
                link_we = (r_step == 3'd2);
            end
            S_NUM: begin
                if (r_step == 3'd1) link_raddr = r_link_rd.ptr;
                link_we    = (r_step == 3'd2) && !r_link_rd.numbered;
                link_waddr = r_sink;
                link_wdata = '{numbered: 1'b1, num: r_next, ptr: r_link_rd.ptr};
            end
            S_QRY: begin
                link_raddr = (r_step == 3'd1) ? r_link_rd.ptr : q_idx;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (alt_we) alt_mem[alt_waddr] <= ALT_BITS'(i_in.altitude);
        r_alt_rd <= alt_mem[alt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) link_mem[link_waddr] <= link_wdata;
        r_link_rd <= link_mem[link_raddr];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_pass      <= '0;
            r_r         <= '0;
            r_c         <= '0;
            r_changed   <= 1'b1;
            r_rows_cfg  <= CFG_W'(1);
            r_cols_cfg  <= CFG_W'(1);
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_OUT reloads the result register itself
            if (o_out.ready && r_state != S_OUT) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROWS: r_rows_cfg <= i_cfg_data;
                    CFG_COLS: r_cols_cfg <= i_cfg_data;
                endcase
                r_changed <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.func == FUNC_WRITE) begin
                            if (wr_ok && !i_cfg_we) r_changed <= 1'b1;
                        end else begin
                            r_qrow  <= i_in.row;
                            r_qcol  <= i_in.col;
                            r_step  <= '0;
                            r_r     <= '0;
                            r_c     <= '0;
                            r_state <= r_changed ? S_DOWN : S_QRY;
                        end
                    end
                end
                S_DOWN: begin
                    // steps 1..5 fold in here, N, W, E, S in that order
                    if (r_step == 3'd1) begin
                        r_best_alt <= r_alt_rd;
                        r_best     <= cur;
                    end else if (cand_lower) begin
                        r_best_alt <= r_alt_rd;
                        r_best     <= nb_addr[cand_k];
                    end
                    if (r_step == 3'd5) begin
                        r_step <= '0;
                        if (last_c) begin
                            r_c <= '0;
                            r_r <= last_r ? '0 : r_r + ROW_W'(1);
                        end else begin
                            r_c <= r_c + COL_W'(1);
                        end
                        if (last_cell) begin
                            r_state <= S_JUMP;
                            r_pass  <= '0;
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_JUMP, S_NUM: begin
                    if (r_step == 3'd1) r_sink <= r_link_rd.ptr;
                    if (r_state == S_NUM && r_step == 3'd2 && !r_link_rd.numbered)
                        r_next <= r_next + NUM_W'(1);
                    if (r_step == 3'd2) begin
                        r_step <= '0;
                        if (last_c) begin
                            r_c <= '0;
                            r_r <= last_r ? '0 : r_r + ROW_W'(1);
                        end else begin
                            r_c <= r_c + COL_W'(1);
                        end
                        if (last_cell) begin
                            if (r_state == S_NUM) begin
                                if (!i_cfg_we) r_changed <= 1'b0;
                                r_state   <= S_QRY;
                            end else if (r_pass == PASS_W'(CELL_W - 1)) begin
                                r_next  <= '0;
                                r_state <= S_NUM;
                            end else begin
                                r_pass <= r_pass + PASS_W'(1);
                            end
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_QRY: begin
                    if (r_step == 3'd0 && !q_in) begin
                        r_qnum  <= '0;
                        r_state <= S_OUT;
                    end else if (r_step == 3'd2) begin
                        r_qnum  <= r_link_rd.num;
                        r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_num   <= r_qnum;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.basin_number = r_out_num;

    // checks
    a_no_link_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !link_we) else $error("link write while idle");
    a_recompute_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.func == FUNC_QUERY && r_changed && !i_cfg_we) |=> (r_state == S_DOWN))
        else $error("stale map queried");
    a_qry_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRY) |-> !r_changed) else $error("query on changed map");
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT)) else $error("stray result");
endmodule
`default_nettype wire

### sim/steepest_descent_basin_labeler_tb.sv
// Self-checking testbench for the steepest-descent drainage basin labeler.
`default_nettype none
module steepest_descent_basin_labeler_tb;
    import sdbl_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TARGET_ITEMS = 1350;
    localparam int SETTLE       = 60;

    typedef struct {
        logic              func;
        logic [IROW_W-1:0] row;
        logic [ICOL_W-1:0] col;
        logic [IALT_W-1:0] alt;
    } t_basin_req;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    sdbl_in_if  in_ch ();
    sdbl_out_if out_ch ();

    steepest_descent_basin_labeler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // 12-unit clock
    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the labeler: altitude map, active grid, basin labels
    // ------------------------------------------------------------------
    logic [IALT_W-1:0] height_map [CELLS];
    int                drain_to   [CELLS];
    int                sink_label [CELLS];
    logic [NUM_W-1:0]  basin_of   [CELLS];
    int  act_rows = 1;
    int  act_cols = 1;
    bit  map_dirty = 1'b1;

    t_basin_req       pending_beats [$];
    logic [NUM_W-1:0] expected_basins [$];

    int n_writes, n_queries, n_results, n_fail, n_phases, n_items;
    int cycle_count;
    bit quiet_send, quiet_recv;

    // Rebuild every basin label from the current height map.
    function automatic void relabel_basins();
        int idx, best, s, next_num;
        for (int r = 0; r < act_rows; r++)
            for (int c = 0; c < act_cols; c++) begin
                idx  = r * MAX_COLS + c;
                best = idx;
                // strict less-than keeps the first of equal neighbors: N, W, E, S
                if (r > 0 && height_map[idx-MAX_COLS] < height_map[best])
                    best = idx - MAX_COLS;
                if (c > 0 && height_map[idx-1] < height_map[best])
                    best = idx - 1;
                if (c + 1 < act_cols && height_map[idx+1] < height_map[best])
                    best = idx + 1;
                if (r + 1 < act_rows && height_map[idx+MAX_COLS] < height_map[best])
                    best = idx + MAX_COLS;
                drain_to[idx]   = best;
                sink_label[idx] = -1;
            end
        next_num = 0;
        for (int r = 0; r < act_rows; r++)
            for (int c = 0; c < act_cols; c++) begin
                idx = r * MAX_COLS + c;
                s   = idx;
                while (drain_to[s] != s) s = drain_to[s];
                if (sink_label[s] < 0) begin
                    sink_label[s] = next_num;
                    next_num++;
                end
                basin_of[idx] = sink_label[s][NUM_W-1:0];
            end
        map_dirty = 1'b0;
    endfunction

    function automatic void predict_beat(t_basin_req b);
        if (b.func == FUNC_WRITE) begin
            height_map[b.row * MAX_COLS + b.col] = b.alt;
            map_dirty = 1'b1;
            n_writes++;
        end else begin
            if (map_dirty) relabel_basins();
            if (b.row < act_rows && b.col < act_cols)
                expected_basins.push_back(basin_of[b.row * MAX_COLS + b.col]);
            else
                expected_basins.push_back('0);
            n_queries++;
        end
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending beats, predicts on each accepted beat
    // ------------------------------------------------------------------
    t_basin_req on_bus;
    int         send_gap;

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.func     = FUNC_WRITE;
        in_ch.row      = '0;
        in_ch.col      = '0;
        in_ch.altitude = '0;
        out_ch.ready   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_ROWS;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_beat(on_bus);
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    on_bus = pending_beats.pop_front();
                    in_ch.func     <= on_bus.func;
                    in_ch.row      <= on_bus.row;
                    in_ch.col      <= on_bus.col;
                    in_ch.altitude <= on_bus.alt;
                    in_ch.valid    <= 1'b1;
                    send_gap = pick_gap(quiet_send);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, one long hold, compares basin numbers
    // ------------------------------------------------------------------
    int  recv_stall;
    bit  long_hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (expected_basins.size() == 0) begin
                    $display("%0t: unexpected basin beat, expected none, actual %0d",
                             $time, out_ch.basin_number);
                    n_fail++;
                end else begin
                    logic [NUM_W-1:0] want;
                    want = expected_basins.pop_front();
                    if (out_ch.basin_number !== want) begin
                        $display("%0t: basin_number mismatch, expected %0d, actual %0d",
                                 $time, want, out_ch.basin_number);
                        n_fail++;
                    end
                end
            end
            // one long hold while beats are queued, so the result backs up into the input
            if (!long_hold_done && n_results >= 150 && pending_beats.size() > 8) begin
                long_hold_done = 1'b1;
                recv_stall = 600;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                recv_stall = pick_gap(quiet_recv);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time,
                     expected_basins.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_beat(logic func, int row, int col, logic [IALT_W-1:0] alt);
        t_basin_req b;
        b.func = func;
        b.row  = row[IROW_W-1:0];
        b.col  = col[ICOL_W-1:0];
        b.alt  = alt;
        pending_beats.push_back(b);
        n_items++;
    endtask

    // Wait until every beat is accepted and every basin number has come back.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || in_ch.valid || expected_basins.size() != 0);
    endtask

    // Register write, only with the block idle.
    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        int v;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        v = (val == 0) ? 1 : ((val > MAX_ROWS) ? MAX_ROWS : int'(val));
        if (idx == CFG_ROWS) act_rows = v;
        else                 act_cols = (val == 0) ? 1 : ((val > MAX_COLS) ? MAX_COLS : int'(val));
        map_dirty = 1'b1;
    endtask

    function automatic logic [IALT_W-1:0] rand_alt();
        if ($urandom_range(0, 3) != 0) return IALT_W'($urandom_range(0, 3));
        return IALT_W'($urandom);
    endfunction

    // Load every active cell so no query can touch an unwritten height.
    task automatic fill_grid();
        for (int r = 0; r < act_rows; r++)
            for (int c = 0; c < act_cols; c++)
                push_beat(FUNC_WRITE, r, c, rand_alt());
    endtask

    task automatic set_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        n_phases++;
        fill_grid();
    endtask

    // Short bursts of writes then queries; a few beats land anywhere.
    task automatic random_bursts(int bursts);
        for (int k = 0; k < bursts; k++) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 7) == 0)
                    push_beat(FUNC_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                              IALT_W'($urandom));
                else
                    push_beat(FUNC_WRITE, $urandom_range(0, act_rows - 1),
                              $urandom_range(0, act_cols - 1), rand_alt());
            end
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(0, 5) == 0)
                    push_beat(FUNC_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
                              IALT_W'($urandom));
                else
                    push_beat(FUNC_QUERY, $urandom_range(0, act_rows - 1),
                              $urandom_range(0, act_cols - 1), IALT_W'($urandom));
            end
        end
    endtask

    initial begin
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset grid is 1x1: single-cell basin, queries off the grid, far write
        push_beat(FUNC_WRITE, 0, 0, 16'hFFFF);
        push_beat(FUNC_QUERY, 0, 0, 16'h0000);
        push_beat(FUNC_QUERY, 127, 127, 16'hFFFF);
        push_beat(FUNC_WRITE, 127, 127, 16'h0000);
        push_beat(FUNC_QUERY, 0, 0, 16'h0000);
        push_beat(FUNC_QUERY, 0, 1, 16'h0000);

        // oversize row count clamps to the full height, one column wide
        set_grid(8'hFF, 8'd1);
        push_beat(FUNC_QUERY, 0, 0, 16'h0000);
        push_beat(FUNC_QUERY, 127, 0, 16'h0000);
        push_beat(FUNC_WRITE, 64, 0, 16'h0000);
        push_beat(FUNC_QUERY, 63, 0, 16'h0000);

        // zero rows acts as one; full width row
        set_grid(8'd0, 8'd128);
        push_beat(FUNC_QUERY, 0, 127, 16'h0000);
        push_beat(FUNC_QUERY, 0, 0, 16'h0000);
        push_beat(FUNC_QUERY, 1, 0, 16'h0000);

        // flat plateau: every cell its own sink, numbered in raster order
        set_grid(8'd3, 8'd0);
        write_reg(CFG_COLS, 8'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) push_beat(FUNC_WRITE, r, c, 16'd5);
        push_beat(FUNC_QUERY, 2, 2, 16'h0000);
        // a pit in the middle takes all four neighbors
        push_beat(FUNC_WRITE, 1, 1, 16'd0);
        push_beat(FUNC_QUERY, 0, 1, 16'h0000);
        push_beat(FUNC_QUERY, 2, 2, 16'h0000);
        random_bursts(4);

        // the sender pauses until all results are back, then the random phases
        wait_drained();
        while (n_items < TARGET_ITEMS) begin
            quiet_send = ($urandom_range(0, 2) == 0);
            quiet_recv = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) == 0)
                set_grid(CFG_W'($urandom_range(0, 1) ? 0 : $urandom_range(129, 255)),
                         CFG_W'($urandom_range(1, 4)));
            else
                set_grid(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 6)));
            random_bursts($urandom_range(4, 10));
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("Ran %0d grid settings: %0d altitude writes, %0d basin queries,",
                 n_phases, n_writes, n_queries);
        $display("%0d basin numbers checked, %0d mismatches.", n_results, n_fail);
        if (n_fail == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
